// File: design/bilinear_resample_weights_macros.svh
// assertion helpers for the top design file
`ifndef BILINEAR_RESAMPLE_WEIGHTS_MACROS_SVH
`define BILINEAR_RESAMPLE_WEIGHTS_MACROS_SVH

// same-cycle implication, checked out of reset on aclk
`define BRW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset on aclk
`define BRW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/brw_pkg.sv
package brw_pkg;

    // grid defaults
    localparam int GRID_COLS_DEF = 64;
    localparam int GRID_ROWS_DEF = 64;

    // field widths
    localparam int COORD_W = 32;
    localparam int INV_W   = 31;
    localparam int TAG_W   = 16;
    localparam int IDX_W   = 12;
    localparam int WT_W    = 17;
    localparam int AXW_W   = 16;
    // corner positions in half-pixel units
    localparam int HALF_W  = 36;

    // pipeline depth
    localparam int AXIS_STAGES  = 6;
    localparam int INDEX_STAGES = 3;
    localparam int NSTAGE       = AXIS_STAGES + INDEX_STAGES;

    // results per point
    localparam int NRES = 4;
    localparam logic [1:0] LAST_BEAT = 2'd3;

    localparam logic [INV_W-1:0] INV_RESET = 31'd65536;

    // register indexes on the configuration port
    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_INV_PIX  = 3'd2;
    localparam logic [2:0] REG_X_LOW    = 3'd3;
    localparam logic [2:0] REG_X_HIGH   = 3'd4;
    localparam logic [2:0] REG_Y_LOW    = 3'd5;
    localparam logic [2:0] REG_Y_HIGH   = 3'd6;

    // four results of one point
    typedef struct packed {
        logic [NRES-1:0][IDX_W-1:0] idx;
        logic [NRES-1:0][WT_W-1:0]  wt;
    } corner_set_t;

endpackage

// File: design/brw_axis.sv
// pixel coordinate and corner pair of one axis
module brw_axis
    import brw_pkg::*;
(
    input  logic                     aclk,
    input  logic [AXIS_STAGES-1:0]   en,
    input  logic signed [COORD_W-1:0] point,
    input  logic signed [COORD_W-1:0] centre,
    input  logic [INV_W-1:0]         inv,
    output logic signed [HALF_W-1:0] c1_half,
    output logic signed [HALF_W-1:0] c2_half,
    output logic [AXW_W-1:0]         w
);

    logic signed [COORD_W:0] d_reg;
    logic                    neg2_reg, neg3_reg, neg4_reg;
    logic [COORD_W:0]        dmag_reg;
    logic [46:0]             plo_reg;
    logic [47:0]             phi_reg;
    logic [47:0]             m_reg;
    logic [32:0]             r_reg;
    logic [AXW_W-1:0]        w5_reg, w6_reg;
    logic                    pos_reg;
    logic signed [HALF_W-1:0] c1_reg, c2_reg;
    logic signed [HALF_W-1:0] r2;

    assign r2 = HALF_W'({r_reg, 1'b0});

    always_ff @(posedge aclk) begin
        // offset from the grid centre
        if (en[0]) begin
            d_reg <= (COORD_W+1)'(point) - (COORD_W+1)'(centre);
        end
        // sign and magnitude
        if (en[1]) begin
            neg2_reg <= d_reg[COORD_W];
            dmag_reg <= d_reg[COORD_W] ? (COORD_W+1)'(-d_reg) : (COORD_W+1)'(d_reg);
        end
        // partial products against the inverse pixel size
        if (en[2]) begin
            neg3_reg <= neg2_reg;
            plo_reg  <= 47'(dmag_reg[15:0]) * 47'(inv);
            phi_reg  <= 48'(dmag_reg[32:16]) * 48'(inv);
        end
        // magnitude of the pixel coordinate, Q.16
        if (en[3]) begin
            neg4_reg <= neg3_reg;
            m_reg    <= phi_reg + 48'(plo_reg[46:16]);
        end
        // rounded magnitude and axis weight
        if (en[4]) begin
            r_reg   <= {1'b0, m_reg[47:16]} + 33'(m_reg[15]);
            w5_reg  <= {~m_reg[15], m_reg[14:0]};
            pos_reg <= !neg4_reg && (m_reg != 48'd0);
        end
        // corner positions, odd numbers of half pixels
        if (en[5]) begin
            w6_reg <= w5_reg;
            if (pos_reg) begin
                c1_reg <= r2 - HALF_W'(1);
                c2_reg <= r2 + HALF_W'(1);
            end else begin
                c1_reg <= HALF_W'(1) - r2;
                c2_reg <= -HALF_W'(1) - r2;
            end
        end
    end

    assign c1_half = c1_reg;
    assign c2_half = c2_reg;
    assign w       = w6_reg;

endmodule

// File: design/brw_index.sv
// grid indexes and corner weights from the two axes
module brw_index
    import brw_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
) (
    input  logic                      aclk,
    input  logic [INDEX_STAGES-1:0]   en,
    input  logic signed [HALF_W-1:0]  c1x,
    input  logic signed [HALF_W-1:0]  c2x,
    input  logic signed [HALF_W-1:0]  c1y,
    input  logic signed [HALF_W-1:0]  c2y,
    input  logic [AXW_W-1:0]          wx,
    input  logic [AXW_W-1:0]          wy,
    output corner_set_t               res
);

    localparam logic signed [HALF_W-1:0] COL_OFS = HALF_W'(GRID_COLS - 1);
    localparam logic signed [HALF_W-1:0] ROW_OFS = HALF_W'(GRID_ROWS - 1);
    localparam logic [IDX_W-1:0]         ROWS_C  = IDX_W'(GRID_ROWS);
    localparam logic [WT_W-1:0]          ONE_Q16 = 17'd65536;

    logic signed [HALF_W-1:0] hx1_reg, hx2_reg, hy1_reg, hy2_reg;
    logic [NRES-1:0][33:0]    prod_reg;
    logic [IDX_W-1:0]         col1_reg, col2_reg, row1_reg, row2_reg;
    logic [NRES-1:0][WT_W-1:0] wr_reg, wt_reg;
    logic [NRES-1:0][IDX_W-1:0] idx_reg;
    logic [WT_W-1:0]          ax, ay;

    assign ax = ONE_Q16 - {1'b0, wx};
    assign ay = ONE_Q16 - {1'b0, wy};

    // trunc toward zero of h/2, kept to the index width
    function automatic logic [IDX_W-1:0] half_trunc(input logic signed [HALF_W-1:0] h);
        logic [IDX_W:0] s;
        s = h[IDX_W:0] + (IDX_W+1)'(h[HALF_W-1]);
        return s[IDX_W:1];
    endfunction

    always_ff @(posedge aclk) begin
        // grid offsets and raw weight products
        if (en[0]) begin
            hx1_reg     <= c1x + COL_OFS;
            hx2_reg     <= c2x + COL_OFS;
            hy1_reg     <= ROW_OFS - c1y;
            hy2_reg     <= ROW_OFS - c2y;
            prod_reg[0] <= 34'(ax) * 34'(ay);
            prod_reg[1] <= 34'(ax) * 34'(wy);
            prod_reg[2] <= 34'(wx) * 34'(wy);
            prod_reg[3] <= 34'(wx) * 34'(ay);
        end
        // column and row numbers, rounded weights
        if (en[1]) begin
            col1_reg <= half_trunc(hx1_reg);
            col2_reg <= half_trunc(hx2_reg);
            row1_reg <= half_trunc(hy1_reg);
            row2_reg <= half_trunc(hy2_reg);
            for (int k = 0; k < NRES; k++) begin
                wr_reg[k] <= WT_W'((prod_reg[k] + 34'd32768) >> 16);
            end
        end
        // flat grid indexes in corner order
        if (en[2]) begin
            idx_reg[0] <= col1_reg * ROWS_C + row1_reg;
            idx_reg[1] <= col1_reg * ROWS_C + row2_reg;
            idx_reg[2] <= col2_reg * ROWS_C + row2_reg;
            idx_reg[3] <= col2_reg * ROWS_C + row1_reg;
            wt_reg     <= wr_reg;
        end
    end

    assign res.idx = idx_reg;
    assign res.wt  = wt_reg;

endmodule

// File: design/brw_serial.sv
// holds one point's results and hands them out one beat at a time
module brw_serial
    import brw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TAG_W-1:0]  in_tag,
    input  corner_set_t       in_set,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,
    output logic              m_tlast
);

    logic              busy_reg, busy_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [TAG_W-1:0]  tag_reg;
    corner_set_t       set_reg;
    logic              load;

    assign in_ready = !busy_reg || (m_tready && cnt_reg == LAST_BEAT);
    assign load     = in_valid && in_ready;

    // beat counter
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (load) begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
        end else if (busy_reg && m_tready) begin
            if (cnt_reg == LAST_BEAT) begin
                busy_next = 1'b0;
            end
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        if (load) begin
            tag_reg <= in_tag;
            set_reg <= in_set;
        end
    end

    // output beat
    assign m_tvalid = busy_reg;
    assign m_tlast  = (cnt_reg == LAST_BEAT);
    assign m_tdata  = {3'b000, set_reg.wt[cnt_reg], set_reg.idx[cnt_reg], tag_reg};

endmodule

// File: design/bilinear_resample_weights.sv
// the first result beat of a point is offered once the point has left the last pipeline
// stage and been loaded into the output holder
// points leave at the pace of the single result channel (4 beats a point)
// the 9-stage pipeline takes a new point every cycle until the output holder fills
// points outside the window are accepted but give no beats
// reset: synchronous active-low, clears pipeline valids and the output holder, loads
// register defaults (inverse pixel size one, all else zero)
`include "bilinear_resample_weights_macros.svh"

module bilinear_resample_weights
    import brw_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // input points
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // point_x[31:0], point_y[63:32], row_index[79:64]
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // row_tag[15:0], grid_index[27:16], weight[44:28], zero pad
    output logic        m_tlast
);

    logic signed [COORD_W-1:0] center_x_reg, center_y_reg;
    logic signed [COORD_W-1:0] x_low_reg, x_high_reg, y_low_reg, y_high_reg;
    logic [INV_W-1:0]          inv_reg;

    logic signed [COORD_W-1:0] point_x, point_y;
    logic                      win_ok;
    logic [NSTAGE-1:0]         v_reg, v_next, en;
    logic [NSTAGE-1:0][TAG_W-1:0] tag_reg;
    logic                      ser_ready;

    logic signed [HALF_W-1:0]  c1x, c2x, c1y, c2y;
    logic [AXW_W-1:0]          wx, wy;
    corner_set_t               res;

    assign point_x = s_tdata[31:0];
    assign point_y = s_tdata[63:32];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            inv_reg      <= INV_RESET;
            x_low_reg    <= '0;
            x_high_reg   <= '0;
            y_low_reg    <= '0;
            y_high_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_wdata;
                REG_CENTER_Y: center_y_reg <= cfg_wdata;
                REG_INV_PIX:  inv_reg      <= cfg_wdata[INV_W-1:0];
                REG_X_LOW:    x_low_reg    <= cfg_wdata;
                REG_X_HIGH:   x_high_reg   <= cfg_wdata;
                REG_Y_LOW:    y_low_reg    <= cfg_wdata;
                REG_Y_HIGH:   y_high_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // strict window test on the incoming point
    assign win_ok = (point_x > x_low_reg) && (point_x < x_high_reg) &&
                    (point_y > y_low_reg) && (point_y < y_high_reg);

    // stage enables: a stage moves when it is empty or the next one moves
    always_comb begin
        en[NSTAGE-1] = !v_reg[NSTAGE-1] || ser_ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? (s_tvalid && win_ok) : v_reg[0];
        for (int i = 1; i < NSTAGE; i++) begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    assign s_tready = en[0];

    // valid bits and the row tag line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
        if (en[0]) begin
            tag_reg[0] <= s_tdata[79:64];
        end
        for (int i = 1; i < NSTAGE; i++) begin
            if (en[i]) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    brw_axis u_axis_x (
        .aclk    (aclk),
        .en      (en[AXIS_STAGES-1:0]),
        .point   (point_x),
        .centre  (center_x_reg),
        .inv     (inv_reg),
        .c1_half (c1x),
        .c2_half (c2x),
        .w       (wx)
    );

    brw_axis u_axis_y (
        .aclk    (aclk),
        .en      (en[AXIS_STAGES-1:0]),
        .point   (point_y),
        .centre  (center_y_reg),
        .inv     (inv_reg),
        .c1_half (c1y),
        .c2_half (c2y),
        .w       (wy)
    );

    brw_index #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_index (
        .aclk (aclk),
        .en   (en[NSTAGE-1:AXIS_STAGES]),
        .c1x  (c1x),
        .c2x  (c2x),
        .c1y  (c1y),
        .c2y  (c2y),
        .wx   (wx),
        .wy   (wy),
        .res  (res)
    );

    brw_serial u_serial (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (v_reg[NSTAGE-1]),
        .in_ready (ser_ready),
        .in_tag   (tag_reg[NSTAGE-1]),
        .in_set   (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // checks on pipeline and output sequencing
    `BRW_ASSERT_NEXT(a_win_enters, s_tvalid && s_tready && win_ok, v_reg[0], "in-window beat lost at entry")
    `BRW_ASSERT_NEXT(a_tail_holds, v_reg[NSTAGE-1] && !en[NSTAGE-1], v_reg[NSTAGE-1], "stalled point dropped")
    `BRW_ASSERT_NOW(a_front_free, !v_reg[0], s_tready, "empty front stage refuses a beat")
    `BRW_ASSERT_NEXT(a_run_on, m_tvalid && m_tready && !m_tlast, m_tvalid, "point cut short before fourth beat")

endmodule
